// File: rtl/mmm_pkg.sv
// ----------------------------------------------------------------------------
// mmm_pkg
// Shared types and constants for the fixed-point matrix multiply block.
// ----------------------------------------------------------------------------
package mmm_pkg;

  // default dimensions and element format
  localparam int unsigned MAX_DIM     = 8;
  localparam int unsigned VALUE_WIDTH = 32;

  // fixed field widths
  localparam int unsigned DIM_W   = 4;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned ADDR_W  = 6;
  localparam int unsigned ELEM_W  = 32;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  // operation codes of a request
  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_START  = 2'd2
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ROWS_A = 2'd0,
    CFG_INNER  = 2'd1,
    CFG_COLS_B = 2'd2
  } cfg_idx_e;

  // command kinds passed from front to back
  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_START  = 2'd2
  } cmd_e;

  // sequencer states
  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_RUN  = 1'b1
  } seq_state_e;

  typedef struct packed {
    logic [1:0]               operation;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] element_value;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [ELEM_W-1:0] out_value;
    logic                     last_element;
  } out_res_t;

  // queued command
  typedef struct packed {
    cmd_e              kind;
    logic [ADDR_W-1:0] addr;
    logic [ELEM_W-1:0] data;
  } cmd_t;

  // effective dimensions, each as its last index
  typedef struct packed {
    logic [DIM_W-1:0] n_last;
    logic [DIM_W-1:0] m_last;
    logic [DIM_W-1:0] p_last;
  } dims_t;

  // position tag that travels with each product
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             first;
    logic             last_k;
    logic             last_elem;
  } tag_t;

  // register value to last index, clamped to 1..max_dim
  function automatic logic [DIM_W-1:0] eff_last(logic [DIM_W-1:0] v,
                                                logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > max_dim) begin
      r = max_dim - DIM_W'(1);
    end else begin
      r = v - DIM_W'(1);
    end
    return r;
  endfunction

endpackage

// File: rtl/mmm_ram.sv
// ----------------------------------------------------------------------------
// mmm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mmm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mmm_front.sv
// ----------------------------------------------------------------------------
// mmm_front
// Accepts requests, drops unused codes and out-of-range loads, and queues
// load and start commands for the back end.
// ----------------------------------------------------------------------------
module mmm_front #(
  parameter int unsigned MAX_DIM = mmm_pkg::MAX_DIM
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mmm_pkg::in_req_t in_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output mmm_pkg::cmd_t    cmd_o
);

  localparam int unsigned DEPTH = mmm_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  mmm_pkg::cmd_t  entry_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  count_q;
  mmm_pkg::cmd_t  cmd_new;
  logic           keep;
  logic           push, pop;
  logic           in_range;

  // classify the incoming request
  always_comb begin
    in_range = ({1'b0, in_i.row_index} < (mmm_pkg::IDX_W + 1)'(MAX_DIM)) &&
               ({1'b0, in_i.col_index} < (mmm_pkg::IDX_W + 1)'(MAX_DIM));
    cmd_new.addr = mmm_pkg::ADDR_W'(int'(in_i.row_index) * MAX_DIM +
                                    int'(in_i.col_index));
    cmd_new.data = in_i.element_value;
    cmd_new.kind = mmm_pkg::CMD_START;
    keep = 1'b0;
    case (mmm_pkg::op_e'(in_i.operation))
      mmm_pkg::OP_LOAD_A: begin
        cmd_new.kind = mmm_pkg::CMD_LOAD_A;
        keep = in_range;
      end
      mmm_pkg::OP_LOAD_B: begin
        cmd_new.kind = mmm_pkg::CMD_LOAD_B;
        keep = in_range;
      end
      mmm_pkg::OP_START: begin
        cmd_new.kind = mmm_pkg::CMD_START;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready_o  = (count_q < CW'(DEPTH));
  assign push        = in_valid_i && in_ready_o && keep;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = entry_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

// File: rtl/mmm_back.sv
// ----------------------------------------------------------------------------
// mmm_back
// Executes queued commands: loads write the element stores, a start walks
// i, j, k through one multiply-accumulate pipeline and emits C row by row.
// ----------------------------------------------------------------------------
module mmm_back #(
  parameter int unsigned MAX_DIM     = mmm_pkg::MAX_DIM,
  parameter int unsigned VALUE_WIDTH = mmm_pkg::VALUE_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mmm_pkg::dims_t    dims_i,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  mmm_pkg::cmd_t     cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mmm_pkg::out_res_t out_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned VW    = VALUE_WIDTH;
  localparam int unsigned AC    = mmm_pkg::ACC_W;
  localparam int unsigned QW    = AC - mmm_pkg::FRAC_W + 1;
  localparam logic signed [QW-1:0] HI = (QW'(1) <<< (VW - 1)) - QW'(1);
  localparam logic signed [QW-1:0] LO = -HI - QW'(1);

  mmm_pkg::seq_state_e state_q, state_d;
  logic [IW-1:0]   i_q, j_q, k_q;
  logic [IW-1:0]   n_last_q, m_last_q, p_last_q;
  logic            cmd_fire, start_fire;
  logic            stall, advance, issue;
  logic            seq_done;

  logic [AW-1:0]   raddr_a, raddr_b, waddr;
  logic [VW-1:0]   rdata_a, rdata_b;
  logic            we_a, we_b;

  logic            s1_valid_q, s2_valid_q, s3_valid_q;
  mmm_pkg::tag_t   tag0, s1_tag_q, s2_tag_q, s3_tag_q;
  logic signed [2*VW-1:0] prod_q;
  logic signed [AC-1:0]   prod_ext;
  logic signed [AC-1:0]   acc_q, acc_d;
  logic signed [AC:0]     sum;
  logic signed [QW-1:0]   q_round;
  logic signed [VW-1:0]   q_sat;

  logic              out_valid_q;
  mmm_pkg::out_res_t out_q;

  // handshake with the queue
  assign cmd_ready_o = (state_q == mmm_pkg::SEQ_IDLE);
  assign cmd_fire    = cmd_valid_i && cmd_ready_o;
  assign start_fire  = cmd_fire && (cmd_i.kind == mmm_pkg::CMD_START);
  assign we_a        = cmd_fire && (cmd_i.kind == mmm_pkg::CMD_LOAD_A);
  assign we_b        = cmd_fire && (cmd_i.kind == mmm_pkg::CMD_LOAD_B);
  assign waddr       = AW'(cmd_i.addr);

  // pipeline freezes while a finished element waits
  assign stall   = out_valid_q && !out_ready_i;
  assign advance = !stall;
  assign issue   = (state_q == mmm_pkg::SEQ_RUN) && advance;
  assign seq_done = (k_q == m_last_q) && (j_q == p_last_q) && (i_q == n_last_q);

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmm_pkg::SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mmm_pkg::SEQ_IDLE: begin
        if (start_fire) begin
          state_d = mmm_pkg::SEQ_RUN;
        end
      end
      mmm_pkg::SEQ_RUN: begin
        if (issue && seq_done) begin
          state_d = mmm_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_d = mmm_pkg::SEQ_IDLE;
      end
    endcase
  end

  // loop counters and latched shape
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      n_last_q <= '0;
      m_last_q <= '0;
      p_last_q <= '0;
    end else if (start_fire) begin
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      n_last_q <= IW'(dims_i.n_last);
      m_last_q <= IW'(dims_i.m_last);
      p_last_q <= IW'(dims_i.p_last);
    end else if (issue) begin
      if (k_q != m_last_q) begin
        k_q <= k_q + IW'(1);
      end else begin
        k_q <= '0;
        if (j_q != p_last_q) begin
          j_q <= j_q + IW'(1);
        end else begin
          j_q <= '0;
          i_q <= i_q + IW'(1);
        end
      end
    end
  end

  // store read addresses for the current step
  always_comb begin
    raddr_a        = AW'(int'(i_q) * MAX_DIM + int'(k_q));
    raddr_b        = AW'(int'(k_q) * MAX_DIM + int'(j_q));
    tag0.row       = mmm_pkg::IDX_W'(i_q);
    tag0.col       = mmm_pkg::IDX_W'(j_q);
    tag0.first     = (k_q == '0);
    tag0.last_k    = (k_q == m_last_q);
    tag0.last_elem = seq_done;
  end

  mmm_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (cmd_i.data[VW-1:0]),
    .re_i    (issue),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mmm_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (cmd_i.data[VW-1:0]),
    .re_i    (issue),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // saturating accumulate
  always_comb begin
    prod_ext = AC'(prod_q);
    sum      = {acc_q[AC-1], acc_q} + {prod_ext[AC-1], prod_ext};
    if (s2_tag_q.first) begin
      acc_d = prod_ext;
    end else if (sum[AC] != sum[AC-1]) begin
      acc_d = sum[AC] ? {1'b1, {(AC-1){1'b0}}} : {1'b0, {(AC-1){1'b1}}};
    end else begin
      acc_d = sum[AC-1:0];
    end
  end

  // round half up, then clamp to the element range
  always_comb begin
    q_round = $signed({acc_q[AC-1], acc_q[AC-1:mmm_pkg::FRAC_W]}) +
              $signed({{(QW-1){1'b0}}, acc_q[mmm_pkg::FRAC_W-1]});
    if (q_round > HI) begin
      q_sat = HI[VW-1:0];
    end else if (q_round < LO) begin
      q_sat = LO[VW-1:0];
    end else begin
      q_sat = q_round[VW-1:0];
    end
  end

  // pipeline valid bits and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else if (advance) begin
      s1_valid_q  <= issue;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q && s3_tag_q.last_k;
      if (s2_valid_q) begin
        acc_q <= acc_d;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_tag_q <= tag0;
      s2_tag_q <= s1_tag_q;
      s3_tag_q <= s2_tag_q;
      prod_q   <= $signed(rdata_a) * $signed(rdata_b);
      if (s3_valid_q && s3_tag_q.last_k) begin
        out_q.out_row      <= s3_tag_q.row;
        out_q.out_col      <= s3_tag_q.col;
        out_q.out_value    <= mmm_pkg::ELEM_W'(q_sat);
        out_q.last_element <= s3_tag_q.last_elem;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: rtl/matrix_matrix_multiply.sv
// ----------------------------------------------------------------------------
// matrix_matrix_multiply
// Signed Q16.16 matrix product C = A x B with a 64-bit saturating accumulator.
// ----------------------------------------------------------------------------
//  port group  dir  signals                                 carries
//  in          in   in_valid_i / in_ready_o / in_i          load or start request
//  out         out  out_valid_o / out_ready_i / out_o       one element of C
//  cfg         in   cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i
//
//  A load request is written to its store when it reaches the back end; loads
//  behind a start wait until its last read issues. A start issues n*p*m reads
//  through one multiply-accumulate, one per cycle while the output is not
//  stalled; each element of C then passes the store read, product, accumulator
//  and output registers. A stalled output freezes the whole multiply pipeline;
//  the two-entry command queue keeps taking requests until full. Reset clears
//  control state only: the element stores hold nothing defined until written.
// ----------------------------------------------------------------------------
module matrix_matrix_multiply #(
  parameter int unsigned MAX_DIM     = mmm_pkg::MAX_DIM,
  parameter int unsigned VALUE_WIDTH = mmm_pkg::VALUE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mmm_pkg::in_req_t               in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mmm_pkg::out_res_t              out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [mmm_pkg::DIM_W-1:0]      cfg_data_i
);

  logic [mmm_pkg::DIM_W-1:0] rows_a_q, inner_size_q, cols_b_q;
  mmm_pkg::dims_t            dims;
  logic                      cfg_fire;
  logic                      cmd_valid, cmd_ready;
  mmm_pkg::cmd_t             cmd;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q     <= mmm_pkg::DIM_W'(1);
      inner_size_q <= mmm_pkg::DIM_W'(1);
      cols_b_q     <= mmm_pkg::DIM_W'(1);
    end else if (cfg_fire) begin
      case (mmm_pkg::cfg_idx_e'(cfg_index_i))
        mmm_pkg::CFG_ROWS_A: rows_a_q     <= cfg_data_i;
        mmm_pkg::CFG_INNER:  inner_size_q <= cfg_data_i;
        mmm_pkg::CFG_COLS_B: cols_b_q     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // clamped shape
  always_comb begin
    dims.n_last = mmm_pkg::eff_last(rows_a_q, mmm_pkg::DIM_W'(MAX_DIM));
    dims.m_last = mmm_pkg::eff_last(inner_size_q, mmm_pkg::DIM_W'(MAX_DIM));
    dims.p_last = mmm_pkg::eff_last(cols_b_q, mmm_pkg::DIM_W'(MAX_DIM));
  end

  mmm_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  mmm_back #(.MAX_DIM(MAX_DIM), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // the marked element sits at the far corner of C
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.last_element |->
      ({1'b0, out_o.out_row} == dims.n_last) &&
      ({1'b0, out_o.out_col} == dims.p_last))
    else $error("last element not at the corner of C");

  // every element lies inside the configured shape
  a_in_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ({1'b0, out_o.out_row} <= dims.n_last) &&
      ({1'b0, out_o.out_col} <= dims.p_last))
    else $error("result element outside the configured shape");

endmodule
